// ===== design/cbm_pkg.sv =====
// Shared constants and types for the circular bidirectional matcher.
package cbm_pkg;

  localparam int TEXT_MAX = 1024;
  localparam int PAT_MAX  = 64;

  localparam int TAW   = $clog2(TEXT_MAX);
  localparam int TCW   = $clog2(TEXT_MAX + 1);
  localparam int PAW   = $clog2(PAT_MAX);
  localparam int PCW   = $clog2(PAT_MAX + 1);
  localparam int SW    = $clog2(TEXT_MAX + 2 * PAT_MAX + 1);
  localparam int POS_W = 11;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

// ===== design/circular_bidirectional_matcher_core.sv =====
// Naive circular matcher with forward and reversed pattern search.
//
// Load words (pattern or text bytes) are accepted one per cycle while idle. A text
// word with in_last set starts the search, during which in_ready is low. The
// search runs one shared byte comparator over two registered store reads: each
// compared byte passes through ST_RD, which registers both reads, and ST_CMP,
// which compares them. A forward pass over text_count + pattern_count - 1 starts
// is followed, when it misses, by a reversed pass over the same starts, and the
// search then waits in ST_FIN until the output register is free. Error and
// empty-pattern cases go from ST_CHECK straight to ST_FIN. The result sits in
// an output register, and loading resumes while it waits.
module circular_bidirectional_matcher_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic [7:0]               in_char_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [cbm_pkg::POS_W-1:0] out_position,
  output logic                     out_reversed,
  output logic                     out_bad_lengths
);
  import cbm_pkg::*;

  logic [7:0] text_mem [TEXT_MAX];
  logic [7:0] pat_mem  [PAT_MAX];

  state_t state_r, state_nxt;

  logic [TCW-1:0] tc_r, tc_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic           ovf_r, ovf_nxt;

  logic [SW-1:0]  s_r, s_nxt;
  logic [TAW-1:0] j0_r, j0_nxt;
  logic [TAW-1:0] j_r, j_nxt;
  logic [PAW-1:0] k_r, k_nxt;
  logic           rev_r, rev_nxt;

  logic             res_found_r, res_found_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             res_rev_r, res_rev_nxt;
  logic             res_bad_r, res_bad_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_rev_r, out_rev_nxt;
  logic             out_bad_r, out_bad_nxt;

  logic [7:0]     text_q_r, pat_q_r;
  logic [TAW-1:0] text_raddr;
  logic [PAW-1:0] pat_raddr;

  logic accept, is_text, text_full, pat_full, text_wr, pat_wr;
  logic bad_now, empty_pat, byte_eq, last_k, last_s, fin_go;
  logic j_wrap, j0_wrap;
  logic [SW-1:0] pos_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_text   = (in_req_type == REQ_TEXT);
  assign text_full = (tc_r == TCW'(TEXT_MAX));
  assign pat_full  = (pc_r == PCW'(PAT_MAX));
  assign text_wr   = accept && is_text && !text_full;
  assign pat_wr    = accept && !is_text && !pat_full;

  assign bad_now   = ovf_r || (SW'(pc_r) > SW'(tc_r));
  assign empty_pat = (pc_r == '0);
  assign byte_eq   = (text_q_r == pat_q_r);
  assign last_k    = ({1'b0, k_r} + (PAW+1)'(1)) == (PAW+1)'(pc_r);
  assign last_s    = (s_r + SW'(2)) == (SW'(tc_r) + SW'(pc_r));
  assign j_wrap    = ({1'b0, j_r} + (TAW+1)'(1)) == (TAW+1)'(tc_r);
  assign j0_wrap   = ({1'b0, j0_r} + (TAW+1)'(1)) == (TAW+1)'(tc_r);
  assign pos_sum   = rev_r ? (s_r + SW'(pc_r)) : (s_r + SW'(1));
  assign fin_go    = !out_valid_r || out_ready;

  assign text_raddr = j_r;
  assign pat_raddr  = rev_r ? PAW'(pc_r - PCW'(1) - PCW'(k_r)) : k_r;

  always_ff @(posedge clk) begin
    if (text_wr) begin
      text_mem[tc_r[TAW-1:0]] <= in_char_value;
    end
    if (pat_wr) begin
      pat_mem[pc_r[PAW-1:0]] <= in_char_value;
    end
    text_q_r <= text_mem[text_raddr];
    pat_q_r  <= pat_mem[pat_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_text && in_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (bad_now || empty_pat) state_nxt = ST_FIN;
        else state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (byte_eq && last_k) state_nxt = ST_FIN;
        else if (!byte_eq && last_s && rev_r) state_nxt = ST_FIN;
        else state_nxt = ST_RD;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tc_nxt        = tc_r;
    pc_nxt        = pc_r;
    ovf_nxt       = ovf_r;
    s_nxt         = s_r;
    j0_nxt        = j0_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rev_nxt       = rev_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    res_rev_nxt   = res_rev_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_rev_nxt   = out_rev_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      ST_IDLE: begin
        if (text_wr) tc_nxt = tc_r + TCW'(1);
        if (pat_wr) pc_nxt = pc_r + PCW'(1);
        if (accept && ((is_text && text_full) || (!is_text && pat_full))) ovf_nxt = 1'b1;
      end
      ST_CHECK: begin
        res_found_nxt = 1'b0;
        res_pos_nxt   = '0;
        res_rev_nxt   = 1'b0;
        res_bad_nxt   = bad_now;
        s_nxt         = '0;
        j0_nxt        = '0;
        j_nxt         = '0;
        k_nxt         = '0;
        rev_nxt       = 1'b0;
      end
      ST_RD: begin
      end
      ST_CMP: begin
        if (byte_eq) begin
          if (last_k) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = POS_W'(pos_sum);
            res_rev_nxt   = rev_r;
          end else begin
            k_nxt = k_r + PAW'(1);
            j_nxt = j_wrap ? '0 : j_r + TAW'(1);
          end
        end else if (last_s) begin
          // restart over all starts with the reversed pattern
          s_nxt   = '0;
          j0_nxt  = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          rev_nxt = 1'b1;
        end else begin
          s_nxt  = s_r + SW'(1);
          j0_nxt = j0_wrap ? '0 : j0_r + TAW'(1);
          j_nxt  = j0_wrap ? '0 : j0_r + TAW'(1);
          k_nxt  = '0;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          out_rev_nxt   = res_rev_r;
          out_bad_nxt   = res_bad_r;
          tc_nxt        = '0;
          pc_nxt        = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tc_r        <= '0;
      pc_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      pc_r        <= pc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    j0_r        <= j0_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    rev_r       <= rev_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_rev_r   <= res_rev_nxt;
    res_bad_r   <= res_bad_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_rev_r   <= out_rev_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = out_pos_r;
  assign out_reversed    = out_rev_r;
  assign out_bad_lengths = out_bad_r;

  a_bad_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> !out_found_r && !out_rev_r)
    else $error("bad_lengths result reports a match");

  a_miss_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_pos_r == '0)
    else $error("missed search reports a nonzero position");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && fin_go |=> tc_r == '0 && pc_r == '0 && !ovf_r && out_valid_r)
    else $error("search finish did not clear stores or post result");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> {1'b0, k_r} < (PAW+1)'(pc_r))
    else $error("pattern index beyond pattern length");

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> {1'b0, j_r} < (TAW+1)'(tc_r))
    else $error("text index beyond text length");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the circular bidirectional matcher core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             reversed;
    logic             bad_lengths;
  } match_t;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    match_t     want;
  } stim_row_t;

  typedef enum int {
    SEQ_PLAIN,
    SEQ_MIXED,
    SEQ_LONG_PAT,
    SEQ_PAT_OVER,
    SEQ_PAT_FULL,
    SEQ_TEXT_FULL,
    SEQ_TEXT_OVER
  } seq_kind_t;

  localparam int NUM_ROWS = 22;
  localparam int RANDOM_WORDS = 1700;
  localparam int RX_HOLD_CYCLES = 3000;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{REQ_TEXT,    8'h00, 1'b1, 1'b1, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'hAA, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'hBB, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'hAA, 1'b1, 1'b1, '{1'b0, 11'd0, 1'b0, 1'b1}},
    '{REQ_PATTERN, 8'hFF, 1'b1, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 11'd1, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h00, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h01, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h01, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h00, 1'b1, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h12, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h34, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h56, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h56, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h34, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h12, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h77, 1'b1, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h80, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h7F, 1'b1, 1'b1, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'h55, 1'b0, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_PATTERN, 8'h55, 1'b1, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'hAA, 1'b1, 1'b0, '{1'b0, 11'd0, 1'b0, 1'b0}}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_req_type;
  logic [7:0]       in_char_value;
  logic             in_last;
  logic             out_valid;
  logic             out_ready;
  logic             out_found;
  logic [POS_W-1:0] out_position;
  logic             out_reversed;
  logic             out_bad_lengths;

  logic [7:0] text_mem [TEXT_MAX];
  logic [7:0] pat_mem [PAT_MAX];
  int         text_len = 0;
  int         pat_len = 0;
  bit         store_overflow = 1'b0;

  match_t expected_q [$];
  int     errors = 0;
  int     words_sent = 0;
  bit     no_gaps = 1'b0;
  bit     rx_hold_req = 1'b0;

  circular_bidirectional_matcher_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_char_value   (in_char_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_reversed    (out_reversed),
    .out_bad_lengths (out_bad_lengths)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int circ_scan(bit rev);
    int         s;
    int         j;
    int         k;
    bit         ok;
    logic [7:0] p;
    if (pat_len == 0 || text_len == 0) return -1;
    for (s = 0; s < text_len + pat_len - 1; s++) begin
      j = s % text_len;
      ok = 1'b1;
      for (k = 0; k < pat_len && ok; k++) begin
        p = rev ? pat_mem[pat_len - 1 - k] : pat_mem[k];
        if (text_mem[j] != p) ok = 1'b0;
        j++;
        if (j >= text_len) j = 0;
      end
      if (ok) return s;
    end
    return -1;
  endfunction

  function automatic bit match_step(logic req, logic [7:0] ch, logic lst,
                                    output match_t res);
    int s;
    res = '0;
    if (req == REQ_PATTERN) begin
      if (pat_len < PAT_MAX) begin
        pat_mem[pat_len] = ch;
        pat_len++;
      end else begin
        store_overflow = 1'b1;
      end
      return 1'b0;
    end
    if (text_len < TEXT_MAX) begin
      text_mem[text_len] = ch;
      text_len++;
    end else begin
      store_overflow = 1'b1;
    end
    if (!lst) return 1'b0;
    if (store_overflow || pat_len > text_len) begin
      res.bad_lengths = 1'b1;
    end else begin
      s = circ_scan(1'b0);
      if (s >= 0) begin
        res.found = 1'b1;
        res.position = POS_W'(s + 1);
      end else begin
        s = circ_scan(1'b1);
        if (s >= 0) begin
          res.found = 1'b1;
          res.reversed = 1'b1;
          res.position = POS_W'(s + pat_len);
        end
      end
    end
    text_len = 0;
    pat_len = 0;
    store_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 90));
  endfunction

  function automatic logic [7:0] draw_char(bit two_sym, logic [7:0] sym_a,
                                           logic [7:0] sym_b);
    if (!two_sym) return 8'($urandom);
    return ($urandom_range(0, 1) == 0) ? sym_a : sym_b;
  endfunction

  task automatic send_word(input logic req, input logic [7:0] ch, input logic lst,
                           input bit typed, input match_t typed_res);
    match_t res;
    bit     has_res;
    int     gap;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_char_value <= ch;
    in_last       <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    has_res = match_step(req, ch, lst, res);
    if (has_res) expected_q.push_back(typed ? typed_res : res);
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_sequence(seq_kind_t kind);
    logic [7:0] pat_buf [$];
    logic [7:0] text_buf [$];
    int         pn;
    int         tn;
    int         r;
    int         at;
    int         k;
    int         pi;
    int         ti;
    int         embed_pct;
    bit         two_sym;
    bit         flip;
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    no_gaps = ($urandom_range(0, 4) == 0);
    two_sym = ($urandom_range(0, 2) != 0);
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    embed_pct = 0;
    case (kind)
      SEQ_PLAIN: begin
        r = int'($urandom_range(0, 99));
        if (r < 5) pn = 0;
        else if (r < 90) pn = int'($urandom_range(1, 5));
        else pn = int'($urandom_range(6, 12));
        tn = pn + int'($urandom_range(0, 20));
        embed_pct = 60;
      end
      SEQ_MIXED: begin
        pn = int'($urandom_range(0, 5));
        tn = pn + int'($urandom_range(0, 12));
        embed_pct = 40;
      end
      SEQ_LONG_PAT: begin
        tn = int'($urandom_range(1, 6));
        pn = tn + int'($urandom_range(1, 4));
      end
      SEQ_PAT_OVER: begin
        pn = PAT_MAX + int'($urandom_range(1, 4));
        tn = int'($urandom_range(1, 90));
      end
      SEQ_PAT_FULL: begin
        pn = PAT_MAX;
        tn = PAT_MAX + int'($urandom_range(0, 40));
        two_sym = 1'b0;
        embed_pct = 70;
      end
      SEQ_TEXT_FULL: begin
        pn = PAT_MAX;
        tn = TEXT_MAX;
        two_sym = 1'b0;
        embed_pct = 100;
      end
      default: begin
        pn = int'($urandom_range(0, 4));
        tn = TEXT_MAX + int'($urandom_range(1, 3));
        two_sym = 1'b0;
      end
    endcase
    if (tn < 1) tn = 1;
    for (k = 0; k < pn; k++) pat_buf.push_back(draw_char(two_sym, sym_a, sym_b));
    for (k = 0; k < tn; k++) text_buf.push_back(draw_char(two_sym, sym_a, sym_b));
    if (pn > 0 && pn <= tn && int'($urandom_range(0, 99)) < embed_pct) begin
      at = (kind == SEQ_TEXT_FULL) ? tn - 20 : int'($urandom_range(0, tn - 1));
      flip = 1'($urandom_range(0, 1));
      for (k = 0; k < pn; k++)
        text_buf[(at + k) % tn] = flip ? pat_buf[pn - 1 - k] : pat_buf[k];
    end
    if (kind == SEQ_MIXED) begin
      pi = 0;
      ti = 0;
      while (pi < pn || ti < tn - 1) begin
        if (ti >= tn - 1 || (pi < pn && $urandom_range(0, 1) == 1)) begin
          send_word(REQ_PATTERN, pat_buf[pi], 1'($urandom_range(0, 1)), 1'b0, '0);
          pi++;
        end else begin
          send_word(REQ_TEXT, text_buf[ti], 1'b0, 1'b0, '0);
          ti++;
        end
      end
    end else begin
      for (k = 0; k < pn; k++)
        send_word(REQ_PATTERN, pat_buf[k], ($urandom_range(0, 19) == 0), 1'b0, '0);
      for (k = 0; k < tn - 1; k++)
        send_word(REQ_TEXT, text_buf[k], 1'b0, 1'b0, '0);
    end
    send_word(REQ_TEXT, text_buf[tn - 1], 1'b1, 1'b0, '0);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    errors++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual found=%0b pos=%0d rev=%0b bad=%0b",
                 $time, out_found, out_position, out_reversed, out_bad_lengths);
      end else begin
        want = expected_q.pop_front();
        if (out_found !== want.found)
          note_mismatch("found", want.found, out_found);
        if (out_position !== want.position)
          note_mismatch("position", want.position, out_position);
        if (out_reversed !== want.reversed)
          note_mismatch("reversed", want.reversed, out_reversed);
        if (out_bad_lengths !== want.bad_lengths)
          note_mismatch("bad_lengths", want.bad_lengths, out_bad_lengths);
      end
    end
  end

  initial begin
    int on_len;
    int off_len;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        on_len = ($urandom_range(0, 6) == 0) ? int'($urandom_range(50, 200))
                                             : int'($urandom_range(1, 8));
        out_ready <= 1'b1;
        repeat (on_len) @(posedge clk);
        off_len = idle_len();
        if (off_len > 0) begin
          out_ready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int        i;
    int        seq_no;
    int        r;
    int        big_full_at;
    int        big_over_at;
    int        hold_at;
    bit        full_done;
    bit        over_done;
    seq_kind_t kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_PATTERN;
    in_char_value = 8'h00;
    in_last = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++)
      send_word(DIRECTED[i].req, DIRECTED[i].ch, DIRECTED[i].lst,
                DIRECTED[i].typed, DIRECTED[i].want);

    hold_at = int'($urandom_range(3, 5));
    big_full_at = int'($urandom_range(8, 20));
    big_over_at = int'($urandom_range(8, 20));
    full_done = 1'b0;
    over_done = 1'b0;
    seq_no = 0;
    while (words_sent < NUM_ROWS + RANDOM_WORDS || !full_done || !over_done) begin
      if (seq_no == hold_at) rx_hold_req = 1'b1;
      if (seq_no == big_full_at) begin
        run_sequence(SEQ_TEXT_FULL);
        full_done = 1'b1;
      end
      if (seq_no == big_over_at) begin
        run_sequence(SEQ_TEXT_OVER);
        over_done = 1'b1;
      end
      r = int'($urandom_range(0, 99));
      if (r < 70) kind = SEQ_PLAIN;
      else if (r < 85) kind = SEQ_MIXED;
      else if (r < 93) kind = SEQ_LONG_PAT;
      else if (r < 97) kind = SEQ_PAT_OVER;
      else kind = SEQ_PAT_FULL;
      run_sequence(kind);
      if (seq_no == 2 || (!rx_hold_req && $urandom_range(0, 99) < 8)) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
      seq_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== circular_bidirectional_matcher_core.f =====
design/cbm_pkg.sv
design/circular_bidirectional_matcher_core.sv
tb/testbench.sv
